>>> hdl/mstb_pkg.sv
// shared types and constants for the mp4 sample-table builder
// no dependencies; every other file in hdl/ uses this package
`default_nettype none

package mstb_pkg;

  localparam int unsigned CountWidth = 32;
  localparam int unsigned FieldWidth = 32;
  localparam int unsigned SumWidth   = 64;
  localparam int unsigned NumSlots   = 7;

  typedef enum logic [2:0] {
    KIND_STTS    = 3'd0,
    KIND_CTTS    = 3'd1,
    KIND_STSS    = 3'd2,
    KIND_STSZ    = 3'd3,
    KIND_SUMMARY = 3'd4
  } mstb_kind_e;

  // slot order inside one frame's entry bundle, drained lowest first
  localparam logic [2:0] SLOT_CLOSE_STTS = 3'd0;
  localparam logic [2:0] SLOT_CLOSE_CTTS = 3'd1;
  localparam logic [2:0] SLOT_STSS       = 3'd2;
  localparam logic [2:0] SLOT_STSZ       = 3'd3;
  localparam logic [2:0] SLOT_FLUSH_STTS = 3'd4;
  localparam logic [2:0] SLOT_FLUSH_CTTS = 3'd5;
  localparam logic [2:0] SLOT_SUMMARY    = 3'd6;

  typedef struct packed {
    logic [FieldWidth-1:0] frame_size;
    logic [FieldWidth-1:0] frame_duration;
    logic [FieldWidth-1:0] comp_delay;
    logic                  sync_flag;
    logic                  track_end;
  } mstb_frame_t;

  // everything one frame produces, ready to be drained beat by beat
  typedef struct packed {
    logic [NumSlots-1:0]   pend;
    logic [CountWidth-1:0] close_dur_len;
    logic [FieldWidth-1:0] close_dur_val;
    logic [CountWidth-1:0] close_dly_len;
    logic [FieldWidth-1:0] close_dly_val;
    logic [CountWidth-1:0] sample;
    logic [FieldWidth-1:0] size;
    logic [CountWidth-1:0] flush_dur_len;
    logic [FieldWidth-1:0] flush_dur_val;
    logic [CountWidth-1:0] flush_dly_len;
    logic [FieldWidth-1:0] flush_dly_val;
    logic [FieldWidth-1:0] uniform_size;
    logic [SumWidth-1:0]   byte_sum;
    logic [SumWidth-1:0]   tick_sum;
    logic [CountWidth-1:0] dur_runs;
    logic [CountWidth-1:0] dly_runs;
    logic [CountWidth-1:0] key_total;
    logic                  uniform;
    logic                  nonzero_delay;
  } mstb_bundle_t;

endpackage

`default_nettype wire

>>> hdl/mstb_frame_if.sv
// frame record channel and table entry channel, valid/ready handshake
// depends on mstb_pkg for field widths
`default_nettype none

interface mstb_frame_if;
  logic                               valid;
  logic                               ready;
  logic [mstb_pkg::FieldWidth-1:0]    frame_size;
  logic [mstb_pkg::FieldWidth-1:0]    frame_duration;
  logic [mstb_pkg::FieldWidth-1:0]    comp_delay;
  logic                               sync_flag;
  logic                               track_end;

  modport source (
    output valid, frame_size, frame_duration, comp_delay, sync_flag, track_end,
    input  ready
  );
  modport sink (
    input  valid, frame_size, frame_duration, comp_delay, sync_flag, track_end,
    output ready
  );
endinterface

interface mstb_entry_if;
  logic                               valid;
  logic                               ready;
  logic [2:0]                         table_kind;
  logic [31:0]                        entry_tally;
  logic [31:0]                        entry_value;
  logic [63:0]                        total_bytes;
  logic [63:0]                        total_ticks;
  logic [31:0]                        duration_runs;
  logic [31:0]                        delay_runs;
  logic [31:0]                        key_total;
  logic                               sizes_uniform;
  logic                               delay_table_needed;
  logic                               last_of_run;

  modport source (
    output valid, table_kind, entry_tally, entry_value, total_bytes, total_ticks,
           duration_runs, delay_runs, key_total, sizes_uniform, delay_table_needed,
           last_of_run,
    input  ready
  );
  modport sink (
    input  valid, table_kind, entry_tally, entry_value, total_bytes, total_ticks,
           duration_runs, delay_runs, key_total, sizes_uniform, delay_table_needed,
           last_of_run,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/mstb_run_tracker.sv
// per-track run state: stts/ctts run lengths, sample numbering, totals
// builds the entry bundle for one frame; depends on mstb_pkg
`default_nettype none

module mstb_run_tracker (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     accept_i,
  input  wire mstb_pkg::mstb_frame_t frame_i,
  output mstb_pkg::mstb_bundle_t  bundle_o
);

  localparam int unsigned CW = mstb_pkg::CountWidth;
  localparam int unsigned FW = mstb_pkg::FieldWidth;
  localparam int unsigned SW = mstb_pkg::SumWidth;

  logic          first_q, first_d;
  logic [FW-1:0] dur_val_q, dur_val_d;
  logic [CW-1:0] dur_len_q, dur_len_d;
  logic [FW-1:0] dly_val_q, dly_val_d;
  logic [CW-1:0] dly_len_q, dly_len_d;
  logic [CW-1:0] sample_q, sample_d;
  logic [FW-1:0] first_size_q, first_size_d;
  logic          uniform_q, uniform_d;
  logic [SW-1:0] byte_sum_q, byte_sum_d;
  logic [SW-1:0] tick_sum_q, tick_sum_d;
  logic [CW-1:0] dur_runs_q, dur_runs_d;
  logic [CW-1:0] dly_runs_q, dly_runs_d;
  logic [CW-1:0] key_cnt_q, key_cnt_d;
  logic          nz_q, nz_d;

  logic close_dur, close_dly;

  always_comb begin
    close_dur    = 1'b0;
    close_dly    = 1'b0;
    dur_val_d    = frame_i.frame_duration;
    dur_len_d    = CW'(1);
    dly_val_d    = frame_i.comp_delay;
    dly_len_d    = CW'(1);
    first_size_d = frame_i.frame_size;
    uniform_d    = 1'b1;
    dur_runs_d   = dur_runs_q;
    dly_runs_d   = dly_runs_q;
    if (!first_q) begin
      first_size_d = first_size_q;
      uniform_d    = uniform_q && (frame_i.frame_size == first_size_q);
      if (frame_i.frame_duration == dur_val_q) begin
        dur_val_d = dur_val_q;
        dur_len_d = dur_len_q + CW'(1);
      end else begin
        close_dur  = 1'b1;
        dur_runs_d = dur_runs_q + CW'(1);
      end
      if (frame_i.comp_delay == dly_val_q) begin
        dly_val_d = dly_val_q;
        dly_len_d = dly_len_q + CW'(1);
      end else begin
        close_dly  = 1'b1;
        dly_runs_d = dly_runs_q + CW'(1);
      end
    end
    first_d    = 1'b0;
    sample_d   = sample_q + CW'(1);
    byte_sum_d = byte_sum_q + SW'(frame_i.frame_size);
    tick_sum_d = tick_sum_q + SW'(frame_i.frame_duration);
    nz_d       = nz_q || (frame_i.comp_delay != '0);
    key_cnt_d  = frame_i.sync_flag ? key_cnt_q + CW'(1) : key_cnt_q;
  end

  // bundle for the current frame; close entries carry the old run
  always_comb begin
    bundle_o = '0;
    bundle_o.pend[mstb_pkg::SLOT_CLOSE_STTS] = close_dur;
    bundle_o.pend[mstb_pkg::SLOT_CLOSE_CTTS] = close_dly;
    bundle_o.pend[mstb_pkg::SLOT_STSS]       = frame_i.sync_flag;
    bundle_o.pend[mstb_pkg::SLOT_STSZ]       = 1'b1;
    bundle_o.pend[mstb_pkg::SLOT_FLUSH_STTS] = frame_i.track_end;
    bundle_o.pend[mstb_pkg::SLOT_FLUSH_CTTS] = frame_i.track_end;
    bundle_o.pend[mstb_pkg::SLOT_SUMMARY]    = frame_i.track_end;
    bundle_o.close_dur_len = dur_len_q;
    bundle_o.close_dur_val = dur_val_q;
    bundle_o.close_dly_len = dly_len_q;
    bundle_o.close_dly_val = dly_val_q;
    bundle_o.sample        = sample_d;
    bundle_o.size          = frame_i.frame_size;
    bundle_o.flush_dur_len = dur_len_d;
    bundle_o.flush_dur_val = dur_val_d;
    bundle_o.flush_dly_len = dly_len_d;
    bundle_o.flush_dly_val = dly_val_d;
    bundle_o.uniform_size  = uniform_d ? first_size_d : '0;
    bundle_o.byte_sum      = byte_sum_d;
    bundle_o.tick_sum      = tick_sum_d;
    bundle_o.dur_runs      = dur_runs_d + CW'(1);
    bundle_o.dly_runs      = dly_runs_d + CW'(1);
    bundle_o.key_total     = key_cnt_d;
    bundle_o.uniform       = uniform_d;
    bundle_o.nonzero_delay = nz_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q      <= 1'b1;
      dur_val_q    <= '0;
      dur_len_q    <= '0;
      dly_val_q    <= '0;
      dly_len_q    <= '0;
      sample_q     <= '0;
      first_size_q <= '0;
      uniform_q    <= 1'b1;
      byte_sum_q   <= '0;
      tick_sum_q   <= '0;
      dur_runs_q   <= '0;
      dly_runs_q   <= '0;
      key_cnt_q    <= '0;
      nz_q         <= 1'b0;
    end else if (accept_i && frame_i.track_end) begin
      // track done: back to the reset picture
      first_q      <= 1'b1;
      dur_val_q    <= '0;
      dur_len_q    <= '0;
      dly_val_q    <= '0;
      dly_len_q    <= '0;
      sample_q     <= '0;
      first_size_q <= '0;
      uniform_q    <= 1'b1;
      byte_sum_q   <= '0;
      tick_sum_q   <= '0;
      dur_runs_q   <= '0;
      dly_runs_q   <= '0;
      key_cnt_q    <= '0;
      nz_q         <= 1'b0;
    end else if (accept_i) begin
      first_q      <= first_d;
      dur_val_q    <= dur_val_d;
      dur_len_q    <= dur_len_d;
      dly_val_q    <= dly_val_d;
      dly_len_q    <= dly_len_d;
      sample_q     <= sample_d;
      first_size_q <= first_size_d;
      uniform_q    <= uniform_d;
      byte_sum_q   <= byte_sum_d;
      tick_sum_q   <= tick_sum_d;
      dur_runs_q   <= dur_runs_d;
      dly_runs_q   <= dly_runs_d;
      key_cnt_q    <= key_cnt_d;
      nz_q         <= nz_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/mp4_sample_table_builder.sv
// top level of the mp4 sample-table builder: frame in, table entries out
// depends on mstb_pkg, mstb_frame_if/mstb_entry_if and mstb_run_tracker
`default_nettype none

// One frame record per input beat, one table entry per output beat. Every
// frame yields its stsz entry, an stss entry when it is a key frame, and a
// closed stts and/or ctts run entry when its duration or delay differs from
// the open run. The frame flagged track_end also flushes both open runs and
// is followed by a summary beat with the totals; the run state then starts
// over for the next track. Entries of one frame come out in the order
// closed stts, closed ctts, stss, stsz, flushed stts, flushed ctts, summary,
// and last_of_run marks the final one. Throughput: one entry per clock while
// entry_o.ready is high, and a frame yields 1 to 7 entries (typically 1
// or 2 for steady streams, up to 4 with run changes and a key frame). The
// limit is the single entry register feeding the output; the next frame is
// taken in the same cycle the previous frame's last entry moves into that
// register, so there is no bubble between frames.

module mp4_sample_table_builder (
  input  wire           clk_i,
  input  wire           rst_ni,
  mstb_frame_if.sink    frame_i,
  mstb_entry_if.source  entry_o
);

  localparam int unsigned NS = mstb_pkg::NumSlots;

  mstb_pkg::mstb_frame_t  frame;
  mstb_pkg::mstb_bundle_t bundle_d, bundle_q;
  logic [NS-1:0]          pend_q, pend_d, pend_rest, pick;
  logic [2:0]             pick_idx;
  logic                   frame_beat, out_load;

  // output holding register, one entry
  logic                   out_valid_q;
  mstb_pkg::mstb_kind_e   kind_q, kind_d;
  logic [31:0]            count_q, count_d;
  logic [31:0]            value_q, value_d;
  logic [63:0]            bytes_q, bytes_d;
  logic [63:0]            ticks_q, ticks_d;
  logic [31:0]            druns_q, druns_d;
  logic [31:0]            cruns_q, cruns_d;
  logic [31:0]            keys_q, keys_d;
  logic                   uni_q, uni_d;
  logic                   nz_q, nz_d;
  logic                   last_q, last_d;

  assign frame.frame_size     = frame_i.frame_size;
  assign frame.frame_duration = frame_i.frame_duration;
  assign frame.comp_delay     = frame_i.comp_delay;
  assign frame.sync_flag      = frame_i.sync_flag;
  assign frame.track_end      = frame_i.track_end;

  mstb_run_tracker u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (frame_beat),
    .frame_i  (frame),
    .bundle_o (bundle_d)
  );

  // lowest pending slot goes next
  always_comb begin
    pick_idx = mstb_pkg::SLOT_CLOSE_STTS;
    for (int i = NS - 1; i >= 0; i--) begin
      if (pend_q[i]) pick_idx = 3'(i);
    end
  end

  assign pick       = pend_q & ~(pend_q - NS'(1));
  assign out_load   = !out_valid_q || entry_o.ready;
  assign pend_rest  = out_load ? (pend_q & ~pick) : pend_q;
  // take a frame once the previous bundle has fully moved out
  assign frame_i.ready = (pend_rest == '0);
  assign frame_beat    = frame_i.valid && frame_i.ready;
  assign pend_d        = frame_beat ? bundle_d.pend : pend_rest;

  // format the picked slot as an output entry
  always_comb begin
    kind_d  = mstb_pkg::KIND_STSZ;
    count_d = 32'(bundle_q.sample);
    value_d = bundle_q.size;
    bytes_d = '0;
    ticks_d = '0;
    druns_d = '0;
    cruns_d = '0;
    keys_d  = '0;
    uni_d   = 1'b0;
    nz_d    = 1'b0;
    last_d  = ((pend_q & ~pick) == '0);
    case (pick_idx)
      mstb_pkg::SLOT_CLOSE_STTS: begin
        kind_d  = mstb_pkg::KIND_STTS;
        count_d = 32'(bundle_q.close_dur_len);
        value_d = bundle_q.close_dur_val;
      end
      mstb_pkg::SLOT_CLOSE_CTTS: begin
        kind_d  = mstb_pkg::KIND_CTTS;
        count_d = 32'(bundle_q.close_dly_len);
        value_d = bundle_q.close_dly_val;
      end
      mstb_pkg::SLOT_STSS: begin
        kind_d  = mstb_pkg::KIND_STSS;
        value_d = '0;
      end
      mstb_pkg::SLOT_STSZ: begin
        kind_d  = mstb_pkg::KIND_STSZ;
      end
      mstb_pkg::SLOT_FLUSH_STTS: begin
        kind_d  = mstb_pkg::KIND_STTS;
        count_d = 32'(bundle_q.flush_dur_len);
        value_d = bundle_q.flush_dur_val;
      end
      mstb_pkg::SLOT_FLUSH_CTTS: begin
        kind_d  = mstb_pkg::KIND_CTTS;
        count_d = 32'(bundle_q.flush_dly_len);
        value_d = bundle_q.flush_dly_val;
      end
      mstb_pkg::SLOT_SUMMARY: begin
        kind_d  = mstb_pkg::KIND_SUMMARY;
        value_d = bundle_q.uniform_size;
        bytes_d = bundle_q.byte_sum;
        ticks_d = bundle_q.tick_sum;
        druns_d = 32'(bundle_q.dur_runs);
        cruns_d = 32'(bundle_q.dly_runs);
        keys_d  = 32'(bundle_q.key_total);
        uni_d   = bundle_q.uniform;
        nz_d    = bundle_q.nonzero_delay;
      end
      default: begin
        kind_d  = mstb_pkg::KIND_STSZ;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (out_load) begin
        out_valid_q <= (pend_q != '0);
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (frame_beat) begin
      bundle_q <= bundle_d;
    end
    if (out_load && (pend_q != '0)) begin
      kind_q  <= kind_d;
      count_q <= count_d;
      value_q <= value_d;
      bytes_q <= bytes_d;
      ticks_q <= ticks_d;
      druns_q <= druns_d;
      cruns_q <= cruns_d;
      keys_q  <= keys_d;
      uni_q   <= uni_d;
      nz_q    <= nz_d;
      last_q  <= last_d;
    end
  end

  assign entry_o.valid              = out_valid_q;
  assign entry_o.table_kind         = kind_q;
  assign entry_o.entry_tally        = count_q;
  assign entry_o.entry_value        = value_q;
  assign entry_o.total_bytes        = bytes_q;
  assign entry_o.total_ticks        = ticks_q;
  assign entry_o.duration_runs      = druns_q;
  assign entry_o.delay_runs         = cruns_q;
  assign entry_o.key_total          = keys_q;
  assign entry_o.sizes_uniform      = uni_q;
  assign entry_o.delay_table_needed = nz_q;
  assign entry_o.last_of_run        = last_q;

  // every accepted frame leaves at least its stsz entry pending
  a_stsz_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_beat |=> pend_q[mstb_pkg::SLOT_STSZ])
    else $error("frame accepted without stsz entry pending");

  // flushed runs never outlive the summary that follows them
  a_flush_before_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q[mstb_pkg::SLOT_FLUSH_STTS] || pend_q[mstb_pkg::SLOT_FLUSH_CTTS])
      |-> pend_q[mstb_pkg::SLOT_SUMMARY])
    else $error("flush entry pending without summary");

  // the summary is always the closing beat of its frame
  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (kind_q == mstb_pkg::KIND_SUMMARY)) |-> last_q)
    else $error("summary entry not marked last_of_run");

  // a new frame only enters once nothing of the old one is left behind
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_beat |-> (out_load || (pend_q == '0)))
    else $error("frame accepted while entries still pending");

endmodule

`default_nettype wire
